@@ design/gcc_pkg.sv @@
// Shared constants and types of the grid component counter.
package gcc_pkg;

  localparam int ROWS_DEFAULT    = 128;
  localparam int COLUMNS_DEFAULT = 128;

  localparam int ROW_W     = 7;
  localparam int COL_W     = 7;
  localparam int COUNT_W   = 14;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 8'd128;
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 8'd128;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_column;
    logic             cell_value;
  } gcc_item_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } gcc_result_t;

endpackage

@@ design/gcc_if.sv @@
// Valid/ready channel interfaces for input items and region counts.
interface gcc_in_if import gcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ROW_W-1:0] cell_row;
  logic [COL_W-1:0] cell_column;
  logic             cell_value;

  modport source (output valid, kind, cell_row, cell_column, cell_value, input ready);
  modport sink (input valid, kind, cell_row, cell_column, cell_value, output ready);
endinterface

interface gcc_out_if import gcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] region_count;

  modport source (output valid, region_count, input ready);
  modport sink (input valid, region_count, output ready);
endinterface

@@ design/gcc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module gcc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/gcc_engine.sv @@
// Sequencer that clears, scans and flood-fills the grid held in RAM.
module gcc_engine import gcc_pkg::*; #(
  parameter int MAX_ROWS    = ROWS_DEFAULT,
  parameter int MAX_COLUMNS = COLUMNS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  output logic              item_ready,
  input  gcc_item_t         item,
  input  logic [CFG_W-1:0]  row_count,
  input  logic [CFG_W-1:0]  column_count,
  input  logic              res_ready,
  output gcc_result_t       res
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int KRW   = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
  localparam int KCW   = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CLR      = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CHK = 4'd4;
  localparam logic [3:0] S_POP      = 4'd5;
  localparam logic [3:0] S_POP_WAIT = 4'd6;
  localparam logic [3:0] S_NBR      = 4'd7;
  localparam logic [3:0] S_NBR_CHK  = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;
  localparam logic [3:0] S_CLR_END  = 4'd10;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  logic [3:0]         state_r, state_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [RW-1:0]      sr_r, sr_nxt, cr_r, cr_nxt;
  logic [CW-1:0]      sc_r, sc_nxt, cc_r, cc_nxt;
  logic [AW-1:0]      nb_addr_r, nb_addr_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [AW:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [KRW-1:0] row_cfg_ext, row_item_ext, rows_clamp;
  logic [KCW-1:0] col_cfg_ext, col_item_ext, cols_clamp;
  logic [RW:0]    rows_lim;
  logic [CW:0]    cols_lim;
  logic           wr_ok;
  logic [AW-1:0]  item_addr, scan_addr, nb_addr;
  logic           nb_ok;
  logic [RW-1:0]  nb_row;
  logic [CW-1:0]  nb_col;
  logic           last_col, last_row;
  logic [3:0]     adv_state;
  logic [RW-1:0]  adv_sr;
  logic [CW-1:0]  adv_sc;

  logic          c_we;
  logic [AW-1:0] c_waddr;
  logic [1:0]    c_wdata, c_q;
  logic          g_q, v_q;
  logic          q_we;
  logic [AW-1:0] q_waddr, q_wdata, q_q;
  logic [AW-1:0] rd_addr;

  // Each cell entry holds the filled bit above the visited bit.
  assign g_q = c_q[1];
  assign v_q = c_q[0];

  assign row_cfg_ext  = KRW'(row_count);
  assign col_cfg_ext  = KCW'(column_count);
  assign rows_clamp   = (row_cfg_ext > KRW'(MAX_ROWS)) ? KRW'(MAX_ROWS) : row_cfg_ext;
  assign cols_clamp   = (col_cfg_ext > KCW'(MAX_COLUMNS)) ? KCW'(MAX_COLUMNS) : col_cfg_ext;
  assign rows_lim     = rows_clamp[RW:0];
  assign cols_lim     = cols_clamp[CW:0];

  assign row_item_ext = KRW'(item.cell_row);
  assign col_item_ext = KCW'(item.cell_column);
  assign wr_ok        = (row_item_ext < KRW'(MAX_ROWS)) && (col_item_ext < KCW'(MAX_COLUMNS));
  assign item_addr    = {row_item_ext[RW-1:0], col_item_ext[CW-1:0]};
  assign scan_addr    = {sr_r, sc_r};

  always_comb begin
    nb_row = cr_r;
    nb_col = cc_r;
    nb_ok  = 1'b0;
    case (dir_r)
      DIR_RIGHT: begin
        nb_col = cc_r + 1'b1;
        nb_ok  = (({1'b0, cc_r} + 1'b1) < cols_lim);
      end
      DIR_LEFT: begin
        nb_col = cc_r - 1'b1;
        nb_ok  = (cc_r != '0);
      end
      DIR_DOWN: begin
        nb_row = cr_r + 1'b1;
        nb_ok  = (({1'b0, cr_r} + 1'b1) < rows_lim);
      end
      DIR_UP: begin
        nb_row = cr_r - 1'b1;
        nb_ok  = (cr_r != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end
  assign nb_addr = {nb_row, nb_col};

  assign last_col = (({1'b0, sc_r} + 1'b1) >= cols_lim);
  assign last_row = (({1'b0, sr_r} + 1'b1) >= rows_lim);

  always_comb begin
    adv_sr    = sr_r;
    adv_sc    = sc_r;
    adv_state = S_SCAN_RD;
    if (!last_col) begin
      adv_sc = sc_r + 1'b1;
    end else if (!last_row) begin
      adv_sc = '0;
      adv_sr = sr_r + 1'b1;
    end else begin
      adv_state = S_DONE;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    sr_nxt      = sr_r;
    sc_nxt      = sc_r;
    cr_nxt      = cr_r;
    cc_nxt      = cc_r;
    nb_addr_nxt = nb_addr_r;
    dir_nxt     = dir_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    c_we        = 1'b0;
    c_waddr     = cnt_r;
    c_wdata     = 2'b00;
    q_we        = 1'b0;
    q_waddr     = tail_r[AW-1:0];
    q_wdata     = nb_addr_r;
    rd_addr     = scan_addr;
    case (state_r)
      S_INIT: begin
        c_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          if (item.kind == KIND_WRITE) begin
            c_we    = wr_ok;
            c_waddr = item_addr;
            c_wdata = {item.cell_value, 1'b0};
          end else begin
            count_nxt = '0;
            cnt_nxt   = '0;
            state_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        // The entry read in the previous cycle is written back with its visited bit cleared.
        rd_addr = cnt_r;
        c_we    = (cnt_r != '0);
        c_waddr = cnt_r - 1'b1;
        c_wdata = {g_q, 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = S_CLR_END;
        end
      end
      S_CLR_END: begin
        c_we      = 1'b1;
        c_waddr   = cnt_r - 1'b1;
        c_wdata   = {g_q, 1'b0};
        sr_nxt    = '0;
        sc_nxt    = '0;
        state_nxt = ((rows_lim == '0) || (cols_lim == '0)) ? S_DONE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (g_q && !v_q) begin
          c_we     = 1'b1;
          c_waddr  = scan_addr;
          c_wdata  = 2'b11;
          q_we     = 1'b1;
          q_waddr  = '0;
          q_wdata  = scan_addr;
          head_nxt = '0;
          tail_nxt = (AW + 1)'(1);
          if (count_r != '1) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_POP;
        end else begin
          sr_nxt    = adv_sr;
          sc_nxt    = adv_sc;
          state_nxt = adv_state;
        end
      end
      S_POP: begin
        if (head_r == tail_r) begin
          sr_nxt    = adv_sr;
          sc_nxt    = adv_sc;
          state_nxt = adv_state;
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cr_nxt    = q_q[AW-1:CW];
        cc_nxt    = q_q[CW-1:0];
        dir_nxt   = DIR_RIGHT;
        state_nxt = S_NBR;
      end
      S_NBR: begin
        rd_addr = nb_addr;
        if (nb_ok) begin
          nb_addr_nxt = nb_addr;
          state_nxt   = S_NBR_CHK;
        end else if (dir_r == DIR_UP) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end
      S_NBR_CHK: begin
        if (g_q && !v_q) begin
          c_we     = 1'b1;
          c_waddr  = nb_addr_r;
          c_wdata  = 2'b11;
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        if (dir_r == DIR_UP) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = S_NBR;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r      <= sr_nxt;
    sc_r      <= sc_nxt;
    cr_r      <= cr_nxt;
    cc_r      <= cc_nxt;
    nb_addr_r <= nb_addr_nxt;
    dir_r     <= dir_nxt;
  end

  gcc_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (rd_addr),
    .rdata (c_q)
  );

  gcc_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r[AW-1:0]),
    .rdata (q_q)
  );

  assign item_ready = (state_r == S_IDLE);
  assign res.valid  = (state_r == S_DONE);
  assign res.count  = count_r;

endmodule

@@ design/grid_component_counter.sv @@
// Top level of the grid component counter: configuration, engine and result register.
//
// The input channel carries one beat per item. A write beat (kind 0) stores one
// grid cell; writes outside the grid are dropped. A count beat (kind 1) returns
// one beat on the output channel with the number of 4-connected regions of
// filled cells within row_count rows and column_count columns.
// A count first reads every cell and writes it back with its visited mark cleared.
// It then scans the region cell by cell. Each filled cell not yet visited opens a
// new region and is marked and put on the fill queue; each cell taken off the
// queue has its neighbors checked right, left, down and up, and every in-range
// filled neighbor not yet visited is marked and queued. A region ends when the
// queue is empty, and the scan then goes on from the next cell.
// One item is worked on at a time; the input is ready only while the engine idles.
// After reset a clearing pass empties the grid, and no input beat is taken until
// it ends; configuration writes are taken at any time.
// The result sits in an output register; while the receiver stalls it holds, and
// new write beats are still accepted. A finished count waits for the register.
module grid_component_counter import gcc_pkg::*; #(
  parameter int MAX_ROWS    = ROWS_DEFAULT,
  parameter int MAX_COLUMNS = COLUMNS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gcc_in_if.sink               in_ch,
  gcc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]   row_count_r, column_count_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_free;
  gcc_item_t          item;
  gcc_result_t        res;

  assign item.kind        = in_ch.kind;
  assign item.cell_row    = in_ch.cell_row;
  assign item.cell_column = in_ch.cell_column;
  assign item.cell_value  = in_ch.cell_value;

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RESET;
      column_count_r <= COLUMN_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count_r    <= cfg_data;
        REG_COLUMN_COUNT: column_count_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      out_count_r <= res.count;
    end
  end

  gcc_engine #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (in_ch.valid),
    .item_ready   (in_ch.ready),
    .item         (item),
    .row_count    (row_count_r),
    .column_count (column_count_r),
    .res_ready    (out_free),
    .res          (res)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.region_count = out_count_r;

endmodule

@@ design/gcc_checker.sv @@
// Port-level checker for the grid component counter and its bind.
module gcc_checker import gcc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_count
);

  a_reset_blocks_input: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during the clearing pass after reset");

  a_count_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_COUNT)) |=> !in_ready)
    else $error("input ready right after a count beat");

  a_write_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_WRITE)) |=> in_ready)
    else $error("input stalled after a write beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_count)))
    else $error("stalled result beat changed or dropped");

endmodule

bind grid_component_counter gcc_checker u_gcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_count (out_ch.region_count)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for the grid component counter: random cell writes and region counts checked against a mirrored grid.
module testbench;
  import gcc_pkg::*;

  localparam int CELL_TOTAL  = ROWS_DEFAULT * COLUMNS_DEFAULT;
  localparam int COUNT_LIMIT = (1 << COUNT_W) - 1;

  class grid_mirror;
    bit               cells [0:CELL_TOTAL-1];
    logic [CFG_W-1:0] row_limit    = ROW_COUNT_RESET;
    logic [CFG_W-1:0] column_limit = COLUMN_COUNT_RESET;
    int unsigned      awaited_counts [$];
    int               errors;
    int               checked;

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      if (index == REG_ROW_COUNT) begin
        row_limit = value;
      end else begin
        column_limit = value;
      end
    endfunction

    function int region_rows();
      return (row_limit > ROWS_DEFAULT) ? ROWS_DEFAULT : int'(row_limit);
    endfunction

    function int region_columns();
      return (column_limit > COLUMNS_DEFAULT) ? COLUMNS_DEFAULT : int'(column_limit);
    endfunction

    function int unsigned tally_regions();
      int          rows;
      int          cols;
      int          r;
      int          c;
      int          nr;
      int          nc;
      int          addr;
      int          dir;
      int unsigned total;
      int          dr [4] = '{0, 0, 1, -1};
      int          dc [4] = '{1, -1, 0, 0};
      bit          seen [0:CELL_TOTAL-1];
      int          frontier [$];
      rows = region_rows();
      cols = region_columns();
      total = 0;
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < cols; c++) begin
          addr = r * COLUMNS_DEFAULT + c;
          if (!cells[addr] || seen[addr]) continue;
          seen[addr] = 1'b1;
          frontier = {frontier, addr};
          while (frontier.size() > 0) begin
            addr = frontier.pop_front();
            for (dir = 0; dir < 4; dir++) begin
              nr = addr / COLUMNS_DEFAULT + dr[dir];
              nc = addr % COLUMNS_DEFAULT + dc[dir];
              if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
              if (!cells[nr * COLUMNS_DEFAULT + nc] || seen[nr * COLUMNS_DEFAULT + nc]) continue;
              seen[nr * COLUMNS_DEFAULT + nc] = 1'b1;
              frontier = {frontier, nr * COLUMNS_DEFAULT + nc};
            end
          end
          if (total < COUNT_LIMIT) total++;
        end
      end
      return total;
    endfunction

    function void apply_item(gcc_item_t item);
      if (item.kind == KIND_WRITE) begin
        if (item.cell_row < ROWS_DEFAULT && item.cell_column < COLUMNS_DEFAULT)
          cells[item.cell_row * COLUMNS_DEFAULT + item.cell_column] = item.cell_value;
      end else begin
        awaited_counts = {awaited_counts, tally_regions()};
      end
    endfunction

    function void check_count(logic [COUNT_W-1:0] actual);
      int unsigned want;
      if (awaited_counts.size() == 0) begin
        errors++;
        $display("%0t: unexpected region count beat: expected none, actual %0d", $time, actual);
        return;
      end
      want = awaited_counts.pop_front();
      checked++;
      if (actual !== want[COUNT_W-1:0]) begin
        errors++;
        $display("%0t: region_count mismatch: expected %0d, actual %0d", $time, want, actual);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  gcc_in_if  in_ch ();
  gcc_out_if out_ch ();

  grid_component_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  grid_mirror        mirror = new();
  longint unsigned   cycle_count = 0;
  longint unsigned   cycle_budget = 8 + CELL_TOTAL + 2000;
  int                items_sent = 0;
  int                counts_sent = 0;
  bit                no_gaps = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    mirror.write_register(index, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_item(gcc_item_t item);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (item.kind == KIND_COUNT)
      cycle_budget += CELL_TOTAL + 12 * mirror.region_rows() * mirror.region_columns() + 200;
    else
      cycle_budget += 20;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.kind = item.kind;
    in_ch.cell_row = item.cell_row;
    in_ch.cell_column = item.cell_column;
    in_ch.cell_value = item.cell_value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    mirror.apply_item(item);
    items_sent++;
  endtask

  task automatic write_cell(int row, int column, bit value);
    gcc_item_t item;
    item.kind = KIND_WRITE;
    item.cell_row = row[ROW_W-1:0];
    item.cell_column = column[COL_W-1:0];
    item.cell_value = value;
    send_item(item);
  endtask

  task automatic ask_count();
    gcc_item_t item;
    item.kind = KIND_COUNT;
    item.cell_row = ROW_W'($urandom_range(0, ROWS_DEFAULT - 1));
    item.cell_column = COL_W'($urandom_range(0, COLUMNS_DEFAULT - 1));
    item.cell_value = 1'($urandom_range(0, 1));
    counts_sent++;
    send_item(item);
  endtask

  task automatic drain_counts();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (mirror.awaited_counts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return CFG_W'($urandom_range(ROWS_DEFAULT, 255));
    if (pick == 2) return CFG_W'(ROWS_DEFAULT);
    return CFG_W'($urandom_range(1, 12));
  endfunction

  initial begin : watchdog
    while (cycle_count < 4 * cycle_budget) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end else if (out_ch.ready !== 1'b1) begin
        @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      mirror.check_count(out_ch.region_count);
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int i;
    int rows;
    int cols;
    int first_item;
    int first_count;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ROW_COUNT;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_WRITE;
    in_ch.cell_row = '0;
    in_ch.cell_column = '0;
    in_ch.cell_value = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    ask_count();
    write_cell(0, 0, 1'b1);
    write_cell(0, 1, 1'b1);
    write_cell(127, 127, 1'b1);
    write_cell(0, 127, 1'b1);
    write_cell(127, 0, 1'b1);
    write_cell(1, 1, 1'b1);
    write_cell(1, 1, 1'b0);
    ask_count();
    drain_counts();
    write_reg(REG_ROW_COUNT, '0);
    ask_count();
    drain_counts();
    write_reg(REG_ROW_COUNT, 8'd1);
    write_reg(REG_COLUMN_COUNT, 8'd1);
    ask_count();
    write_cell(1, 0, 1'b1);
    ask_count();
    drain_counts();
    write_reg(REG_ROW_COUNT, 8'd255);
    write_reg(REG_COLUMN_COUNT, 8'd255);
    ask_count();
    drain_counts();
    write_reg(REG_ROW_COUNT, 8'd2);
    write_reg(REG_COLUMN_COUNT, '0);
    ask_count();
    drain_counts();

    first_item = items_sent;
    first_count = counts_sent;
    phase = 0;
    while (items_sent - first_item < 85 || counts_sent - first_count < 25) begin
      write_reg(REG_ROW_COUNT, pick_size());
      write_reg(REG_COLUMN_COUNT, pick_size());
      rows = mirror.region_rows();
      cols = mirror.region_columns();
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(8, 20);
      for (i = 0; i < n; i++) begin
        if (phase == 1 && i == n / 2) drain_counts();
        if ($urandom_range(0, 3) == 0) begin
          ask_count();
        end else if (rows > 0 && cols > 0 && $urandom_range(0, 99) < 85) begin
          write_cell($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                     $urandom_range(0, 9) < 6);
        end else begin
          write_cell($urandom_range(0, ROWS_DEFAULT - 1), $urandom_range(0, COLUMNS_DEFAULT - 1),
                     1'($urandom_range(0, 1)));
        end
      end
      ask_count();
      drain_counts();
      phase++;
    end

    $display("summary: %0d items sent over %0d phases, %0d region counts checked",
             items_sent, phase, mirror.checked);
    $display("summary: region sizes from 0 to 255 rows and columns, random gaps on both channels");
    if (mirror.errors == 0 && mirror.awaited_counts.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
